### design/assert_macros.svh
// Assertion helpers used by the checker file ppp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed: implication");

// Consequent must hold after the antecedent, delayed by the n argument.
`define ASSERT_DELAYED(label, clk, rst_n, a, n, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (c)) \
		else $error("assertion failed: delayed response");

`endif

### design/ppp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_pkg
// Types and constants of the perspective point projection block.
// ----------------------------------------------------------------------------
package ppp_pkg;

	localparam int COORD_W = 24;
	localparam int CLIP_W  = 42;  // clip coordinate, scale 2^-20
	localparam int NUM_W   = 43;  // X+W or W-Y
	localparam int SCL_W   = 19;  // 8 * viewport extent
	localparam int DIVD_W  = 62;  // scaled numerator
	localparam int QUO_W   = 20;  // quotient bits
	localparam int SCR_W   = 21;
	localparam int LATENCY = 26;  // accept edge to result strobe cycle end

	localparam logic [1:0] ST_VISIBLE = 2'd0;
	localparam logic [1:0] ST_CLIPPED = 2'd1;
	localparam logic [1:0] ST_FAILED  = 2'd2;

	localparam logic [2:0] REG_COL0   = 3'd0;
	localparam logic [2:0] REG_COL1   = 3'd1;
	localparam logic [2:0] REG_COL2   = 3'd2;
	localparam logic [2:0] REG_COL3   = 3'd3;
	localparam logic [2:0] REG_ORIGIN = 3'd4;
	localparam logic [2:0] REG_SIZE   = 3'd5;

	localparam logic signed [CLIP_W-1:0] W_MIN = 42'sd104;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
	} point_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [SCR_W-1:0] screen_x;
		logic [SCR_W-1:0] screen_y;
	} result_t;

	typedef struct packed {
		logic [63:0] col3;
		logic [63:0] col2;
		logic [63:0] col1;
		logic [63:0] col0;
		logic [31:0] origin;
		logic [31:0] size;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [1:0]        status;
		logic [CLIP_W-1:0] cw;
		logic [CLIP_W-1:0] rem_x;
		logic [CLIP_W-1:0] rem_y;
		logic [QUO_W-1:0]  low_x;
		logic [QUO_W-1:0]  low_y;
		logic [QUO_W-1:0]  q_x;
		logic [QUO_W-1:0]  q_y;
	} div_stage_t;

endpackage

### design/perspective_point_projection_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_point_projection_top
// World point through a 4x4 view-projection matrix onto the viewport.
// ----------------------------------------------------------------------------
// A point request is taken every cycle (busy stays low). Its result shows on
// result with done high for one cycle, in request order. Behind five stages
// of matrix multiply, sum, classification and scaling, the 20-stage restoring
// divider forms the screen coordinates, followed by the output register. The
// receiver cannot stall. Configuration writes take effect at once and must
// only be made while no request is in flight.
module perspective_point_projection_top import ppp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  point_t      point,
	output logic        done,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	cfg_t                     cfg_q;
	logic                     valid_s2;
	logic signed [CLIP_W-1:0] clip_s2 [4];
	div_stage_t               div_s5, div_end;
	logic                     vis;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.col0   <= 64'h0000_0000_0000_1000;
			cfg_q.col1   <= 64'h0000_0000_1000_0000;
			cfg_q.col2   <= 64'h0000_1000_0000_0000;
			cfg_q.col3   <= 64'h1000_0000_0000_0000;
			cfg_q.origin <= '0;
			cfg_q.size   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COL0:   cfg_q.col0   <= cfg_data;
				REG_COL1:   cfg_q.col1   <= cfg_data;
				REG_COL2:   cfg_q.col2   <= cfg_data;
				REG_COL3:   cfg_q.col3   <= cfg_data;
				REG_ORIGIN: cfg_q.origin <= cfg_data[31:0];
				REG_SIZE:   cfg_q.size   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	ppp_transform u_transform (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.point    (point),
		.cfg      (cfg_q),
		.valid_s2 (valid_s2),
		.clip_s2  (clip_s2)
	);

	ppp_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.clip_s2  (clip_s2),
		.cfg      (cfg_q),
		.div_s5   (div_s5)
	);

	ppp_divider u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.div_in  (div_s5),
		.div_out (div_end)
	);

	assign vis = div_end.status == ST_VISIBLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div_end.valid;
		end
	end

	// add the viewport corner, zero the screen fields unless visible
	always_ff @(posedge clk) begin
		result.status   <= div_end.status;
		result.screen_x <= vis ? ({1'b0, cfg_q.origin[15:0], 4'b0}
			+ {1'b0, div_end.q_x}) : '0;
		result.screen_y <= vis ? ({1'b0, cfg_q.origin[31:16], 4'b0}
			+ {1'b0, div_end.q_y}) : '0;
	end

endmodule

### design/ppp_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_transform
// Row vector times 4x4 matrix: products in stage 1, column sums in stage 2.
// ----------------------------------------------------------------------------
module ppp_transform import ppp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  point_t                   point,
	input  cfg_t                     cfg,
	output logic                     valid_s2,
	output logic signed [CLIP_W-1:0] clip_s2 [4]
);

	logic [63:0]               cols [4];
	logic signed [39:0]        prod_s1 [4][3];
	logic                      valid_s1;

	assign cols[0] = cfg.col0;
	assign cols[1] = cfg.col1;
	assign cols[2] = cfg.col2;
	assign cols[3] = cfg.col3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_col
		logic signed [15:0] k0, k1, k2, k3;
		assign k0 = cols[c][15:0];
		assign k1 = cols[c][31:16];
		assign k2 = cols[c][47:32];
		assign k3 = cols[c][63:48];

		always_ff @(posedge clk) begin
			prod_s1[c][0] <= point.pos_x * k0;
			prod_s1[c][1] <= point.pos_y * k1;
			prod_s1[c][2] <= point.pos_z * k2;
			// translation row enters at scale 2^-20
			clip_s2[c] <= {{2{prod_s1[c][0][39]}}, prod_s1[c][0]}
				+ {{2{prod_s1[c][1][39]}}, prod_s1[c][1]}
				+ {{2{prod_s1[c][2][39]}}, prod_s1[c][2]}
				+ {{18{k3[15]}}, k3, 8'b0};
		end
	end

endmodule

### design/ppp_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_scale
// Classify the clip point and form the scaled numerators for the divider.
// ----------------------------------------------------------------------------
module ppp_scale import ppp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_s2,
	input  logic signed [CLIP_W-1:0] clip_s2 [4],
	input  cfg_t                     cfg,
	output div_stage_t               div_s5
);

	logic signed [NUM_W-1:0] cx, cy, cz, cw;
	logic signed [NUM_W-1:0] sum_x, dif_x, sum_y, dif_y, dif_z;
	logic [15:0]             vw, vh;
	logic [1:0]              status;
	logic [SCL_W-1:0]        mx, my;

	logic                    valid_s3, valid_s4;
	logic [1:0]              status_s3, status_s4;
	logic [NUM_W-1:0]        nx_s3, ny_s3;
	logic [CLIP_W-1:0]       cw_s3, cw_s4;
	logic [40:0]             px_lo_s4, py_lo_s4;
	logic [39:0]             px_hi_s4, py_hi_s4;
	logic [DIVD_W-1:0]       dx, dy;

	assign vw = cfg.size[15:0];
	assign vh = cfg.size[31:16];
	assign cx = {clip_s2[0][CLIP_W-1], clip_s2[0]};
	assign cy = {clip_s2[1][CLIP_W-1], clip_s2[1]};
	assign cz = {clip_s2[2][CLIP_W-1], clip_s2[2]};
	assign cw = {clip_s2[3][CLIP_W-1], clip_s2[3]};

	assign sum_x = cx + cw;
	assign dif_x = cw - cx;
	assign sum_y = cy + cw;
	assign dif_y = cw - cy;
	assign dif_z = cw - cz;

	always_comb begin
		if (vw <= 16'd1 || vh <= 16'd1 || clip_s2[3] <= W_MIN)
			status = ST_FAILED;
		else if (cz < 0 || dif_z < 0)
			status = ST_FAILED;
		else if (sum_x < 0 || dif_x < 0 || sum_y < 0 || dif_y < 0)
			status = ST_CLIPPED;
		else
			status = ST_VISIBLE;
	end

	assign mx = {vw, 3'b0};
	assign my = {vh, 3'b0};
	assign dx = {px_hi_s4, 22'b0} + {21'b0, px_lo_s4};
	assign dy = {py_hi_s4, 22'b0} + {21'b0, py_lo_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			div_s5   <= '0;
		end else begin
			valid_s3      <= valid_s2;
			valid_s4      <= valid_s3;
			div_s5.valid  <= valid_s4;
			div_s5.status <= status_s4;
			div_s5.cw     <= cw_s4;
			div_s5.rem_x  <= dx[DIVD_W-1:QUO_W];
			div_s5.rem_y  <= dy[DIVD_W-1:QUO_W];
			div_s5.low_x  <= dx[QUO_W-1:0];
			div_s5.low_y  <= dy[QUO_W-1:0];
			div_s5.q_x    <= '0;
			div_s5.q_y    <= '0;
		end
	end

	always_ff @(posedge clk) begin
		status_s3 <= status;
		nx_s3     <= sum_x;
		ny_s3     <= dif_y;
		cw_s3     <= clip_s2[3];

		// split the wide multiply into two partial products
		status_s4 <= status_s3;
		cw_s4     <= cw_s3;
		px_lo_s4  <= nx_s3[21:0] * mx;
		px_hi_s4  <= nx_s3[42:22] * mx;
		py_lo_s4  <= ny_s3[21:0] * my;
		py_hi_s4  <= ny_s3[42:22] * my;
	end

endmodule

### design/ppp_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_divider
// Restoring divider, one quotient bit per stage, x and y side by side.
// ----------------------------------------------------------------------------
module ppp_divider import ppp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  div_stage_t div_in,
	output div_stage_t div_out
);

	div_stage_t stage_s [QUO_W];

	assign div_out = stage_s[QUO_W-1];

	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		div_stage_t      cur;
		logic [CLIP_W:0] tx, ty, dv;
		logic            gx, gy;

		if (i == 0) begin : g_first
			assign cur = div_in;
		end else begin : g_next
			assign cur = stage_s[i-1];
		end

		assign dv = {1'b0, cur.cw};
		assign tx = {cur.rem_x, cur.low_x[QUO_W-1]};
		assign ty = {cur.rem_y, cur.low_y[QUO_W-1]};
		assign gx = tx >= dv;
		assign gy = ty >= dv;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stage_s[i] <= '0;
			end else begin
				stage_s[i].valid  <= cur.valid;
				stage_s[i].status <= cur.status;
				stage_s[i].cw     <= cur.cw;
				stage_s[i].rem_x  <= gx ? CLIP_W'(tx - dv) : tx[CLIP_W-1:0];
				stage_s[i].rem_y  <= gy ? CLIP_W'(ty - dv) : ty[CLIP_W-1:0];
				stage_s[i].low_x  <= {cur.low_x[QUO_W-2:0], 1'b0};
				stage_s[i].low_y  <= {cur.low_y[QUO_W-2:0], 1'b0};
				stage_s[i].q_x    <= {cur.q_x[QUO_W-2:0], gx};
				stage_s[i].q_y    <= {cur.q_y[QUO_W-2:0], gy};
			end
		end
	end

endmodule

### design/ppp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// ppp_checker
// Port-level checks of the projection block, bound to the top level.
// ----------------------------------------------------------------------------
module ppp_checker import ppp_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	logic known_code;
	logic blank;

	assign known_code = result.status == ST_VISIBLE || result.status == ST_CLIPPED
		|| result.status == ST_FAILED;
	assign blank = result.screen_x == '0 && result.screen_y == '0;

	`ASSERT_DELAYED(a_request_answered, clk, arst_n, start && !busy, LATENCY, done)
	`ASSERT_IMPLIES(a_status_code, clk, arst_n, done, known_code)
	`ASSERT_IMPLIES(a_hidden_zero, clk, arst_n, done && result.status != ST_VISIBLE, blank)

endmodule

bind perspective_point_projection_top ppp_checker u_ppp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
